// File: design/kfr_pkg.sv
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types and constants of the K-line frame receiver.
// ----------------------------------------------------------------------------
package kfr_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned MS_W      = 10;

  localparam logic [MS_W-1:0] TIMEOUT_MS_RESET = MS_W'(120);

  // operation codes of an input beat
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_ARM  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MID     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  // format byte: top bits 10, low six bits give the data length
  localparam logic [BYTE_W-1:0] FMT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] FMT_MARK = 8'h80;
  localparam logic [BYTE_W-1:0] LEN_MASK = 8'h3F;
  // format byte, two address bytes and checksum around the data
  localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 7'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
    logic                last;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// File: design/kline_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// kline_frame_receiver_unit
// K-line frame receiver: frames bytes from a UART stream and checks the sum.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat per item, op selects a received
// byte (rx_byte), a one-millisecond tick, or an arm command.
// Output channel (out_valid/out_ready): at most one result beat per item,
// carrying data_byte, position, last and status.
// Config channel (cfg_valid/cfg_ready): cfg_data writes timeout_ms; cfg_ready
// is always high. Write it only while the block is idle.
// Path: an accepted item is captured in the input register, and its result
// is then registered in the result register.
// Throughput: one item per cycle unless a result stalls on out_ready; the state
// update is one pass of logic between the input register and the result register.
// Reset: the receiver is disarmed, both registers are empty and timeout_ms
// returns to TIMEOUT_RESET, 120 by default.
// Stall: while a result waits on a low out_ready, the held item stays in the
// input register and in_ready drops once that register is occupied.
// ----------------------------------------------------------------------------
module kline_frame_receiver_unit #(
  parameter logic [kfr_pkg::MS_W-1:0] TIMEOUT_RESET = kfr_pkg::TIMEOUT_MS_RESET
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kfr_pkg::OP_W-1:0]         op,
  input  logic [kfr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kfr_pkg::BYTE_W-1:0]       data_byte,
  output logic [kfr_pkg::POS_W-1:0]        position,
  output logic                             last,
  output logic [kfr_pkg::STATUS_W-1:0]     status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kfr_pkg::MS_W-1:0]         cfg_data
);
  import kfr_pkg::*;

  logic            [MS_W-1:0] timeout_ms;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ms <= cfg_data;
    end
  end

  assign in_item.op      = op;
  assign in_item.rx_byte = rx_byte;
  // advance the held item whenever the result register has room
  assign step = held_valid && can_load;

  kfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (can_load),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  kfr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .timeout_ms (timeout_ms),
    .step       (step),
    .item       (held_item),
    .res_valid  (res_valid),
    .res        (res)
  );

  kfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign data_byte = out_res.data_byte;
  assign position  = out_res.position;
  assign last      = out_res.last;
  assign status    = out_res.status;

endmodule

// File: design/kfr_in_stage.sv
// ----------------------------------------------------------------------------
// kfr_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module kfr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kfr_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output kfr_pkg::item_t held_item
);
  import kfr_pkg::*;

  logic  held;
  item_t item;

  assign in_ready   = !held || take;
  assign held_valid = held;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: design/kfr_core.sv
// ----------------------------------------------------------------------------
// kfr_core
// Frame state: arming, format detection, checksum and millisecond timeout.
// ----------------------------------------------------------------------------
module kfr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kfr_pkg::MS_W-1:0]      timeout_ms,
  input  logic                          step,
  input  kfr_pkg::item_t                item,
  output logic                          res_valid,
  output kfr_pkg::result_t              res
);
  import kfr_pkg::*;

  logic              armed,        armed_next;
  logic [POS_W-1:0]  bytes_seen,   bytes_seen_next;
  logic [POS_W-1:0]  frame_length, frame_length_next;
  logic [BYTE_W-1:0] running_sum,  running_sum_next;
  logic [MS_W-1:0]   elapsed_ms,   elapsed_ms_next;

  logic [MS_W-1:0]   elapsed_inc;
  logic [POS_W-1:0]  len_eff;
  logic [POS_W:0]    pos_plus;
  logic              is_fmt;

  always_comb begin
    elapsed_inc = (elapsed_ms == {MS_W{1'b1}}) ? elapsed_ms : elapsed_ms + 1'b1;
    is_fmt      = (item.rx_byte & FMT_MASK) == FMT_MARK;
    len_eff     = (bytes_seen == '0)
                  ? FRAME_OVERHEAD + POS_W'(item.rx_byte & LEN_MASK)
                  : frame_length;
    pos_plus    = {1'b0, bytes_seen} + 1'b1;

    armed_next        = armed;
    bytes_seen_next   = bytes_seen;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    elapsed_ms_next   = elapsed_ms;
    res_valid         = 1'b0;
    res.data_byte     = item.rx_byte;
    res.position      = bytes_seen;
    res.last          = 1'b0;
    res.status        = ST_MID;

    if (step) begin
      if (item.op == OP_ARM) begin
        armed_next        = 1'b1;
        bytes_seen_next   = '0;
        frame_length_next = '0;
        running_sum_next  = '0;
        elapsed_ms_next   = '0;
      end else if (armed && item.op == OP_TICK) begin
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc >= timeout_ms) begin
          res_valid     = 1'b1;
          res.data_byte = '0;
          res.last      = 1'b1;
          res.status    = ST_TIMEOUT;
          armed_next    = 1'b0;
        end
      end else if (armed && item.op == OP_BYTE && (bytes_seen != '0 || is_fmt)) begin
        res_valid         = 1'b1;
        frame_length_next = len_eff;
        bytes_seen_next   = pos_plus[POS_W-1:0];
        elapsed_ms_next   = '0;
        if (pos_plus >= {1'b0, len_eff}) begin
          // checksum byte ends the frame
          res.last   = 1'b1;
          res.status = (running_sum == item.rx_byte) ? ST_GOOD : ST_BAD;
          armed_next = 1'b0;
        end else begin
          running_sum_next = running_sum + item.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      bytes_seen   <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      elapsed_ms   <= '0;
    end else begin
      armed        <= armed_next;
      bytes_seen   <= bytes_seen_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      elapsed_ms   <= elapsed_ms_next;
    end
  end

endmodule

// File: design/kfr_out_stage.sv
// ----------------------------------------------------------------------------
// kfr_out_stage
// Result register: holds a result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module kfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             res_valid,
  input  kfr_pkg::result_t res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output kfr_pkg::result_t out_res
);
  import kfr_pkg::*;

  logic    full;
  result_t held;

  assign can_load  = !full || out_ready;
  assign out_valid = full;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= res_valid;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      held <= res;
    end
  end

endmodule
